FILE: rtl/core/tcqs_pkg.sv
package tcqs_pkg;

  // queue geometry
  localparam int QUEUE_DEPTH = 64;
  localparam int TAG_BITS    = 16;
  localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_BITS    = CNT_BITS + 1;
  localparam int RATIO_BITS  = 4;
  localparam int PROD_BITS   = RATIO_BITS + CNT_BITS;

  // stream widths
  localparam int OP_BITS     = 2;
  localparam int STATUS_BITS = 3;
  localparam int IN_TDATA_W  = ((TAG_BITS + 7) / 8) * 8;
  localparam int OUT_RAW_W   = 3 * TAG_BITS + 3 * CNT_BITS;
  localparam int OUT_TDATA_W = ((OUT_RAW_W + 7) / 8) * 8;

  localparam logic [RATIO_BITS-1:0] RATIO_RESET = RATIO_BITS'(3);

  typedef logic [TAG_BITS-1:0]    tag_t;
  typedef logic [PTR_BITS-1:0]    ptr_t;
  typedef logic [CNT_BITS-1:0]    cnt_t;
  typedef logic [STATUS_BITS-1:0] status_t;

  // request kinds
  localparam logic [OP_BITS-1:0] OP_ENQ_NORMAL   = 2'd0;
  localparam logic [OP_BITS-1:0] OP_ENQ_PRIORITY = 2'd1;
  localparam logic [OP_BITS-1:0] OP_SERVE        = 2'd2;

  // result status codes
  localparam status_t ST_ENQUEUED   = 3'd0;
  localparam status_t ST_SERVED_N   = 3'd1;
  localparam status_t ST_SERVED_P   = 3'd2;
  localparam status_t ST_BOTH_EMPTY = 3'd3;
  localparam status_t ST_FULL_DROP  = 3'd4;

  typedef enum logic {
    S_IDLE,
    S_READ
  } sched_state_t;

  // circular index of head plus offset
  function automatic ptr_t ptr_add(input ptr_t head, input cnt_t offs);
    logic [SUM_BITS-1:0] sum;
    sum = SUM_BITS'(head) + SUM_BITS'(offs);
    if (sum >= SUM_BITS'(QUEUE_DEPTH)) begin
      sum = sum - SUM_BITS'(QUEUE_DEPTH);
    end
    return sum[PTR_BITS-1:0];
  endfunction

  // head advance with wrap
  function automatic ptr_t ptr_inc(input ptr_t head);
    if (head == PTR_BITS'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return head + PTR_BITS'(1);
  endfunction

endpackage

FILE: rtl/core/two_class_queue_scheduler.sv
// an enqueue request loads its result into the output register in the cycle after accept,
// a serve first reads the store into its read register, then loads the output register
// one enqueue per cycle unless the output stalls; requests wait while a serve reads the store
// reset: rst_n synchronous active low clears heads, fills, tail tags and the output valid,
// and sets starvation_ratio to 3; the store memories are not cleared
module two_class_queue_scheduler (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration: starvation_ratio
  input  logic                               cfg_we,
  input  logic [tcqs_pkg::RATIO_BITS-1:0]    cfg_wdata,
  // request channel
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [tcqs_pkg::IN_TDATA_W-1:0]    in_tdata,   // tag_in
  input  logic [tcqs_pkg::OP_BITS-1:0]       in_tuser,   // op
  // result channel
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // served_tag, position, normal_count, priority_count, normal_last_tag,
  // priority_last_tag, zero pad
  output logic [tcqs_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic [tcqs_pkg::STATUS_BITS-1:0]   out_tuser   // status
);
  import tcqs_pkg::*;

  // store memories
  tag_t mem_n [QUEUE_DEPTH];
  tag_t mem_p [QUEUE_DEPTH];

  sched_state_t state_r, state_nxt;

  logic [RATIO_BITS-1:0] ratio_r, ratio_nxt;
  ptr_t    n_head_r, n_head_nxt, p_head_r, p_head_nxt;
  cnt_t    n_fill_r, n_fill_nxt, p_fill_r, p_fill_nxt;
  tag_t    n_tail_r, n_tail_nxt, p_tail_r, p_tail_nxt;
  logic    pend_p_r, pend_p_nxt;
  tag_t    rd_n_r, rd_p_r;

  // output register
  logic    out_valid_r, out_valid_nxt;
  status_t out_status_r, out_status_nxt;
  tag_t    out_served_r, out_served_nxt;
  cnt_t    out_pos_r, out_pos_nxt;
  cnt_t    out_ncnt_r, out_ncnt_nxt;
  cnt_t    out_pcnt_r, out_pcnt_nxt;
  tag_t    out_nlast_r, out_nlast_nxt;
  tag_t    out_plast_r, out_plast_nxt;

  logic    acc;
  logic    wr_n_en, wr_p_en, rd_n_en, rd_p_en;
  ptr_t    wr_n_addr, wr_p_addr;
  tag_t    tag;
  logic [PROD_BITS-1:0] guard_prod;
  logic    take_normal;

  assign acc = in_tvalid && in_tready;
  assign tag = in_tdata[TAG_BITS-1:0];
  assign guard_prod = PROD_BITS'(ratio_r) * PROD_BITS'(p_fill_r);
  assign take_normal = (p_fill_r == '0) || (PROD_BITS'(n_fill_r) > guard_prod);
  assign wr_n_addr = ptr_add(n_head_r, n_fill_r);
  assign wr_p_addr = ptr_add(p_head_r, p_fill_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (acc && in_tuser[1] && ((n_fill_r != '0) || (p_fill_r != '0))) begin
          state_nxt = S_READ;
        end
      end
      S_READ: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE:  in_tready = !out_valid_r || out_tready;
      S_READ:  in_tready = 1'b0;
      default: in_tready = 1'b0;
    endcase
  end

  // queue update and result assembly
  always_comb begin
    ratio_nxt      = cfg_we ? cfg_wdata : ratio_r;
    n_head_nxt     = n_head_r;
    p_head_nxt     = p_head_r;
    n_fill_nxt     = n_fill_r;
    p_fill_nxt     = p_fill_r;
    n_tail_nxt     = n_tail_r;
    p_tail_nxt     = p_tail_r;
    pend_p_nxt     = pend_p_r;
    wr_n_en        = 1'b0;
    wr_p_en        = 1'b0;
    rd_n_en        = 1'b0;
    rd_p_en        = 1'b0;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_served_nxt = out_served_r;
    out_pos_nxt    = out_pos_r;
    out_ncnt_nxt   = out_ncnt_r;
    out_pcnt_nxt   = out_pcnt_r;
    out_nlast_nxt  = out_nlast_r;
    out_plast_nxt  = out_plast_r;

    if (acc) begin
      out_status_nxt = ST_ENQUEUED;
      out_served_nxt = '0;
      out_pos_nxt    = '0;
      if (in_tuser[1]) begin
        // serve request
        if ((n_fill_r == '0) && (p_fill_r == '0)) begin
          out_status_nxt = ST_BOTH_EMPTY;
          out_valid_nxt  = 1'b1;
        end else if (take_normal) begin
          rd_n_en        = 1'b1;
          pend_p_nxt     = 1'b0;
          n_head_nxt     = ptr_inc(n_head_r);
          n_fill_nxt     = n_fill_r - CNT_BITS'(1);
          if (n_fill_r == CNT_BITS'(1)) begin
            n_tail_nxt = '0;
          end
          out_status_nxt = ST_SERVED_N;
        end else begin
          rd_p_en        = 1'b1;
          pend_p_nxt     = 1'b1;
          p_head_nxt     = ptr_inc(p_head_r);
          p_fill_nxt     = p_fill_r - CNT_BITS'(1);
          if (p_fill_r == CNT_BITS'(1)) begin
            p_tail_nxt = '0;
          end
          out_status_nxt = ST_SERVED_P;
        end
      end else if (in_tuser[0] == OP_ENQ_PRIORITY[0]) begin
        // enqueue priority
        out_valid_nxt = 1'b1;
        if (p_fill_r == CNT_BITS'(QUEUE_DEPTH)) begin
          out_status_nxt = ST_FULL_DROP;
        end else begin
          wr_p_en     = 1'b1;
          p_fill_nxt  = p_fill_r + CNT_BITS'(1);
          p_tail_nxt  = tag;
          out_pos_nxt = p_fill_r + CNT_BITS'(1);
        end
      end else begin
        // enqueue normal
        out_valid_nxt = 1'b1;
        if (n_fill_r == CNT_BITS'(QUEUE_DEPTH)) begin
          out_status_nxt = ST_FULL_DROP;
        end else begin
          wr_n_en     = 1'b1;
          n_fill_nxt  = n_fill_r + CNT_BITS'(1);
          n_tail_nxt  = tag;
          out_pos_nxt = n_fill_r + CNT_BITS'(1);
        end
      end
      out_ncnt_nxt  = n_fill_nxt;
      out_pcnt_nxt  = p_fill_nxt;
      out_nlast_nxt = n_tail_nxt;
      out_plast_nxt = p_tail_nxt;
    end

    // popped tag arrives from the store
    if (state_r == S_READ) begin
      out_served_nxt = pend_p_r ? rd_p_r : rd_n_r;
      out_valid_nxt  = 1'b1;
    end
  end

  // store memories, one write and one registered read each
  always_ff @(posedge clk) begin
    if (wr_n_en) begin
      mem_n[wr_n_addr] <= tag;
    end
    if (rd_n_en) begin
      rd_n_r <= mem_n[n_head_r];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_p_en) begin
      mem_p[wr_p_addr] <= tag;
    end
    if (rd_p_en) begin
      rd_p_r <= mem_p[p_head_r];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ratio_r     <= RATIO_RESET;
      n_head_r    <= '0;
      p_head_r    <= '0;
      n_fill_r    <= '0;
      p_fill_r    <= '0;
      n_tail_r    <= '0;
      p_tail_r    <= '0;
      pend_p_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ratio_r     <= ratio_nxt;
      n_head_r    <= n_head_nxt;
      p_head_r    <= p_head_nxt;
      n_fill_r    <= n_fill_nxt;
      p_fill_r    <= p_fill_nxt;
      n_tail_r    <= n_tail_nxt;
      p_tail_r    <= p_tail_nxt;
      pend_p_r    <= pend_p_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_served_r <= out_served_nxt;
    out_pos_r    <= out_pos_nxt;
    out_ncnt_r   <= out_ncnt_nxt;
    out_pcnt_r   <= out_pcnt_nxt;
    out_nlast_r  <= out_nlast_nxt;
    out_plast_r  <= out_plast_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = OUT_TDATA_W'({out_plast_r, out_nlast_r, out_pcnt_r, out_ncnt_r,
                                    out_pos_r, out_served_r});

  // checks
  a_read_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |-> !out_valid_r)
    else $error("serve read pending while output register is occupied");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (n_fill_r <= CNT_BITS'(QUEUE_DEPTH)) && (p_fill_r <= CNT_BITS'(QUEUE_DEPTH)))
    else $error("queue fill beyond depth");

  a_empty_tail: assert property (@(posedge clk) disable iff (!rst_n)
    ((n_fill_r == '0) |-> (n_tail_r == '0)) and ((p_fill_r == '0) |-> (p_tail_r == '0)))
    else $error("empty queue holds a tail tag");

  a_enq_result: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && !in_tuser[1]) |=> (out_valid_r && (state_r == S_IDLE)))
    else $error("enqueue request produced no result");

endmodule
